// File: rtl/sgsg_pkg.sv
// Shared types and constants for the stratified grid sample generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package sgsg_pkg;

	// Fixed field widths of the stream and configuration ports.
	localparam int STRATA_W   = 8;
	localparam int SIZE_W     = 16;
	localparam int RAND_IN_W  = 16;
	localparam int PROD_W     = 32;
	localparam int BASE_W     = STRATA_W + SIZE_W;
	localparam int IN_DATA_W  = 2 * SIZE_W + 4 * RAND_IN_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Input beat kinds carried on s_tuser.
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_NEXT  = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIX_STRATA_U  = 3'd0,
		REG_PIX_STRATA_V  = 3'd1,
		REG_LENS_STRATA_U = 3'd2,
		REG_LENS_STRATA_V = 3'd3,
		REG_JITTER_PIX    = 3'd4,
		REG_JITTER_LENS   = 3'd5,
		REG_IMG_COLUMNS   = 3'd6,
		REG_IMG_ROWS      = 3'd7
	} cfg_reg_t;

	// Sequencer steps: one per multiply or divide, then result hand-off.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SC_V,
		ST_SC_LU,
		ST_SC_LV,
		ST_BU,
		ST_BV,
		ST_AU,
		ST_AV,
		ST_IU,
		ST_IV,
		ST_WU,
		ST_WV,
		ST_LU,
		ST_LV,
		ST_DONE
	} seq_state_t;

endpackage

`default_nettype wire

// File: rtl/sgsg_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on sgsg_pkg for operand and product widths.
`default_nettype none

module sgsg_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [sgsg_pkg::PROD_W-1:0]   mcand,
	input  wire logic [sgsg_pkg::STRATA_W-1:0] mplier,
	output logic                             done,
	output logic [sgsg_pkg::PROD_W-1:0]        prod
);
	import sgsg_pkg::*;

	localparam int CW = $clog2(STRATA_W + 1);

	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [PROD_W-1:0]   mcand_q;
	logic [STRATA_W-1:0] mplier_q;
	logic [PROD_W-1:0]   acc_q;

	// Control: count the multiplier bits and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STRATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: most significant multiplier bit first, product wraps modulo 2^PROD_W.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= {acc_q[PROD_W-2:0], 1'b0} + (mplier_q[STRATA_W-1] ? mcand_q : '0);
			mplier_q <= {mplier_q[STRATA_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

// File: rtl/sgsg_div.sv
// Restoring fractional divider: one quotient bit per cycle for num/den.
// Flags num >= den, in which case the quotient is not meaningful.
`default_nettype none

module sgsg_div #(
	parameter int DW = 40,
	parameter int QW = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic               over,
	output logic [QW-1:0]      quot
);
	import sgsg_pkg::*;

	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quot_q;
	logic          over_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          take;

	// One restoring step: shift the remainder and try to subtract the divisor.
	always_comb begin
		shifted = {rem_q, 1'b0};
		diff    = shifted - {1'b0, den_q};
		take    = (shifted >= {1'b0, den_q});
	end

	// Control: count quotient bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: an oversized quotient starts from a zero remainder and is discarded.
	always_ff @(posedge clk) begin
		if (start) begin
			over_q <= (num >= den);
			rem_q  <= (num >= den) ? '0 : num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= take ? diff[DW-1:0] : shifted[DW-1:0];
			quot_q <= {quot_q[QW-2:0], take};
		end
	end

	assign done = done_q;
	assign over = over_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

// File: rtl/stratified_grid_sample_generator.sv
// Stratified grid sample generator: sequencer, stratum counters and result register.
// Depends on sgsg_pkg, sgsg_mul and sgsg_div.
//
//   channel   signals                              beat contents
//   s_*       s_tvalid s_tready s_tdata s_tuser    start or next request
//   m_*       m_tvalid m_tready m_tdata m_tlast    sample count or one sample
//   cfg_*     cfg_wr_en cfg_index cfg_data         register write, no read-back
//
// One request is in work at a time. A start beat takes three multiplies on the shared
// serial multiplier. A next beat takes four multiplies and six divides, the divides on
// the shared serial divider. A new beat is taken while a result waits in the output
// register; the sequencer stalls only if a second result is ready before the first leaves.
// Reset restores the registers to their defaults and clears the stratum counters.
`default_nettype none

module stratified_grid_sample_generator #(
	parameter int FRACTION_BITS = 24,
	parameter int RANDOM_BITS   = 16,
	localparam int OUT_BITS     = sgsg_pkg::PROD_W + 6 * FRACTION_BITS + 2,
	localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Request stream.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// pixel_column, pixel_row, rand_pixel_u, rand_pixel_v, rand_lens_u, rand_lens_v
	input  wire logic [sgsg_pkg::IN_DATA_W-1:0]  s_tdata,
	// action
	input  wire logic                            s_tuser,
	// Result stream.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// sample_count, image_u, image_v, stratum_width_u, stratum_width_v,
	// aperture_u, aperture_v, zero fill
	output logic [OUT_W-1:0]                     m_tdata,
	// last_sample
	output logic                                 m_tlast,
	// Configuration writes.
	input  wire logic                            cfg_wr_en,
	input  wire logic [sgsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sgsg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sgsg_pkg::*;

	localparam int F  = FRACTION_BITS;
	localparam int R  = RANDOM_BITS;
	localparam int DW = BASE_W + R;
	localparam logic [R-1:0] HALF = {1'b1, {(R-1){1'b0}}};

	// Configuration registers.
	logic [STRATA_W-1:0] pstr_u_q, pstr_v_q, lstr_u_q, lstr_v_q;
	logic                jit_pix_q, jit_lens_q;
	logic [SIZE_W-1:0]   cols_q, rows_q;

	// Pixel state.
	logic [STRATA_W-1:0] sub_u_q, sub_v_q, lens_u_q, lens_v_q;
	logic [SIZE_W-1:0]   col_q, row_q;

	// Request in work and intermediate results.
	logic              act_q;
	logic [R-1:0]      off_pu_q, off_pv_q, off_lu_q, off_lv_q;
	logic [PROD_W-1:0] count_q;
	logic [BASE_W-1:0] bu_q, bv_q, au_q, av_q;
	logic [F-1:0]      img_u_q, img_v_q, ap_u_q, ap_v_q;
	logic [F:0]        wid_u_q, wid_v_q;

	// Output register.
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic             out_last_q;

	seq_state_t state_q, state_d;
	logic       run_q;

	logic [STRATA_W-1:0] su, sv, lu, lv;
	logic [SIZE_W-1:0]   cols, rows;
	logic                accept, out_free, finish;
	logic                wu, wv, wlu, wlv;

	logic                mul_start, mul_done;
	logic [PROD_W-1:0]   mul_mcand, mul_prod;
	logic [STRATA_W-1:0] mul_mplier;
	logic                div_start, div_done, div_over;
	logic [DW-1:0]       div_num, div_den;
	logic [F-1:0]        div_quot;
	logic [F-1:0]        pos_res;
	logic [F:0]          wid_res;

	logic [R+RAND_IN_W-1:0] rpu_ext, rpv_ext, rlu_ext, rlv_ext;
	logic [OUT_BITS-1:0]    out_bits;

	// Zero counts and sizes act as one.
	always_comb begin
		su   = (pstr_u_q == '0) ? STRATA_W'(1) : pstr_u_q;
		sv   = (pstr_v_q == '0) ? STRATA_W'(1) : pstr_v_q;
		lu   = (lstr_u_q == '0) ? STRATA_W'(1) : lstr_u_q;
		lv   = (lstr_v_q == '0) ? STRATA_W'(1) : lstr_v_q;
		cols = (cols_q == '0) ? SIZE_W'(1) : cols_q;
		rows = (rows_q == '0) ? SIZE_W'(1) : rows_q;
	end

	// Configuration write decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pstr_u_q   <= STRATA_W'(1);
			pstr_v_q   <= STRATA_W'(1);
			lstr_u_q   <= STRATA_W'(1);
			lstr_v_q   <= STRATA_W'(1);
			jit_pix_q  <= 1'b0;
			jit_lens_q <= 1'b0;
			cols_q     <= SIZE_W'(1);
			rows_q     <= SIZE_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PIX_STRATA_U:  pstr_u_q   <= cfg_data[STRATA_W-1:0];
				REG_PIX_STRATA_V:  pstr_v_q   <= cfg_data[STRATA_W-1:0];
				REG_LENS_STRATA_U: lstr_u_q   <= cfg_data[STRATA_W-1:0];
				REG_LENS_STRATA_V: lstr_v_q   <= cfg_data[STRATA_W-1:0];
				REG_JITTER_PIX:    jit_pix_q  <= cfg_data[0];
				REG_JITTER_LENS:   jit_lens_q <= cfg_data[0];
				REG_IMG_COLUMNS:   cols_q     <= cfg_data[SIZE_W-1:0];
				REG_IMG_ROWS:      rows_q     <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign finish   = (state_q == ST_DONE) && out_free;

	// Random fractions cut or widened to RANDOM_BITS.
	always_comb begin
		rpu_ext = {{R{1'b0}}, s_tdata[3*SIZE_W-1:2*SIZE_W]};
		rpv_ext = {{R{1'b0}}, s_tdata[4*SIZE_W-1:3*SIZE_W]};
		rlu_ext = {{R{1'b0}}, s_tdata[5*SIZE_W-1:4*SIZE_W]};
		rlv_ext = {{R{1'b0}}, s_tdata[6*SIZE_W-1:5*SIZE_W]};
	end

	// Latch the request; offsets are the random fraction or the stratum center.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= s_tuser;
			off_pu_q <= jit_pix_q ? rpu_ext[R-1:0] : HALF;
			off_pv_q <= jit_pix_q ? rpv_ext[R-1:0] : HALF;
			off_lu_q <= jit_lens_q ? rlu_ext[R-1:0] : HALF;
			off_lv_q <= jit_lens_q ? rlv_ext[R-1:0] : HALF;
		end
	end

	// Wrap conditions of the four counters, checked before stepping.
	always_comb begin
		wu  = ({1'b0, sub_u_q} + 9'd1) >= {1'b0, su};
		wv  = ({1'b0, sub_v_q} + 9'd1) >= {1'b0, sv};
		wlu = ({1'b0, lens_u_q} + 9'd1) >= {1'b0, lu};
		wlv = ({1'b0, lens_v_q} + 9'd1) >= {1'b0, lv};
	end

	// Pixel state: a start latches the pixel, a finished sample steps the odometer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			sub_u_q  <= '0;
			sub_v_q  <= '0;
			lens_u_q <= '0;
			lens_v_q <= '0;
		end else if (accept && s_tuser == ACT_START) begin
			col_q    <= s_tdata[SIZE_W-1:0];
			row_q    <= s_tdata[2*SIZE_W-1:SIZE_W];
			sub_u_q  <= '0;
			sub_v_q  <= '0;
			lens_u_q <= '0;
			lens_v_q <= '0;
		end else if (finish && act_q == ACT_NEXT) begin
			if (!wu) begin
				sub_u_q <= sub_u_q + 1'b1;
			end else begin
				sub_u_q <= '0;
				if (!wv) begin
					sub_v_q <= sub_v_q + 1'b1;
				end else begin
					sub_v_q <= '0;
					if (!wlu) begin
						lens_u_q <= lens_u_q + 1'b1;
					end else begin
						lens_u_q <= '0;
						lens_v_q <= wlv ? '0 : lens_v_q + 1'b1;
					end
				end
			end
		end
	end

	// Sequencer state register and launch flag for the shared units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			run_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start) begin
				run_q <= 1'b1;
			end else if (mul_done || div_done) begin
				run_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_tuser == ACT_START) ? ST_SC_V : ST_BU;
				end
			end
			ST_SC_V:  if (mul_done) state_d = ST_SC_LU;
			ST_SC_LU: if (mul_done) state_d = ST_SC_LV;
			ST_SC_LV: if (mul_done) state_d = ST_DONE;
			ST_BU:    if (mul_done) state_d = ST_BV;
			ST_BV:    if (mul_done) state_d = ST_AU;
			ST_AU:    if (mul_done) state_d = ST_AV;
			ST_AV:    if (mul_done) state_d = ST_IU;
			ST_IU:    if (div_done) state_d = ST_IV;
			ST_IV:    if (div_done) state_d = ST_WU;
			ST_WU:    if (div_done) state_d = ST_WV;
			ST_WV:    if (div_done) state_d = ST_LU;
			ST_LU:    if (div_done) state_d = ST_LV;
			ST_LV:    if (div_done) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Unit operands per step.
	always_comb begin
		mul_start  = 1'b0;
		mul_mcand  = '0;
		mul_mplier = '0;
		div_start  = 1'b0;
		div_num    = '0;
		div_den    = '0;
		unique case (state_q)
			ST_SC_V: begin
				mul_start  = !run_q;
				mul_mcand  = {{(PROD_W-STRATA_W){1'b0}}, su};
				mul_mplier = sv;
			end
			ST_SC_LU: begin
				mul_start  = !run_q;
				mul_mcand  = count_q;
				mul_mplier = lu;
			end
			ST_SC_LV: begin
				mul_start  = !run_q;
				mul_mcand  = count_q;
				mul_mplier = lv;
			end
			ST_BU: begin
				mul_start  = !run_q;
				mul_mcand  = {{(PROD_W-SIZE_W){1'b0}}, cols};
				mul_mplier = su;
			end
			ST_BV: begin
				mul_start  = !run_q;
				mul_mcand  = {{(PROD_W-SIZE_W){1'b0}}, rows};
				mul_mplier = sv;
			end
			ST_AU: begin
				mul_start  = !run_q;
				mul_mcand  = {{(PROD_W-SIZE_W){1'b0}}, col_q};
				mul_mplier = su;
			end
			ST_AV: begin
				mul_start  = !run_q;
				mul_mcand  = {{(PROD_W-SIZE_W){1'b0}}, row_q};
				mul_mplier = sv;
			end
			ST_IU: begin
				div_start = !run_q;
				div_num   = {au_q, off_pu_q};
				div_den   = {bu_q, {R{1'b0}}};
			end
			ST_IV: begin
				div_start = !run_q;
				div_num   = {av_q, off_pv_q};
				div_den   = {bv_q, {R{1'b0}}};
			end
			ST_WU: begin
				div_start = !run_q;
				div_num   = {{(DW-1){1'b0}}, 1'b1};
				div_den   = {{R{1'b0}}, bu_q};
			end
			ST_WV: begin
				div_start = !run_q;
				div_num   = {{(DW-1){1'b0}}, 1'b1};
				div_den   = {{R{1'b0}}, bv_q};
			end
			ST_LU: begin
				div_start = !run_q;
				div_num   = {{SIZE_W{1'b0}}, lens_u_q, off_lu_q};
				div_den   = {{SIZE_W{1'b0}}, lu, {R{1'b0}}};
			end
			ST_LV: begin
				div_start = !run_q;
				div_num   = {{SIZE_W{1'b0}}, lens_v_q, off_lv_q};
				div_den   = {{SIZE_W{1'b0}}, lv, {R{1'b0}}};
			end
			default: ;
		endcase
	end

	// A position at or past one saturates; a full-width stratum reads as one.
	always_comb begin
		pos_res = div_over ? {F{1'b1}} : div_quot;
		wid_res = div_over ? {1'b1, {F{1'b0}}} : {1'b0, div_quot};
	end

	// Capture unit results into the step's register.
	always_ff @(posedge clk) begin
		if (mul_done) begin
			unique case (state_q)
				ST_SC_V, ST_SC_LU, ST_SC_LV: count_q <= mul_prod;
				ST_BU: bu_q <= mul_prod[BASE_W-1:0];
				ST_BV: bv_q <= mul_prod[BASE_W-1:0];
				ST_AU: au_q <= mul_prod[BASE_W-1:0] + {{SIZE_W{1'b0}}, sub_u_q};
				ST_AV: av_q <= mul_prod[BASE_W-1:0] + {{SIZE_W{1'b0}}, sub_v_q};
				default: ;
			endcase
		end
		if (div_done) begin
			unique case (state_q)
				ST_IU: img_u_q <= pos_res;
				ST_IV: img_v_q <= pos_res;
				ST_WU: wid_u_q <= wid_res;
				ST_WV: wid_v_q <= wid_res;
				ST_LU: ap_u_q  <= pos_res;
				ST_LV: ap_v_q  <= pos_res;
				default: ;
			endcase
		end
	end

	// Result beat: a start reports only the count, a sample only the positions and stratum widths.
	always_comb begin
		if (act_q == ACT_START) begin
			out_bits = {{(OUT_BITS-PROD_W){1'b0}}, count_q};
		end else begin
			out_bits = {ap_v_q, ap_u_q, wid_v_q, wid_u_q, img_v_q, img_u_q, {PROD_W{1'b0}}};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q <= {{(OUT_W-OUT_BITS){1'b0}}, out_bits};
			out_last_q <= (act_q == ACT_NEXT) && wu && wv && wlu && wlv;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	sgsg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_mcand),
		.mplier (mul_mplier),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	sgsg_div #(
		.DW (DW),
		.QW (F)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.over   (div_over),
		.quot   (div_quot)
	);

endmodule

`default_nettype wire

// File: tb/stratified_grid_sample_generator_test.sv
// Self-checking testbench for the stratified grid sample generator.
// Depends on sgsg_pkg and the stratified_grid_sample_generator RTL only; it computes its own
// expected beats and compares them with the result stream under random stalls and setups.
module stratified_grid_sample_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sgsg_pkg::*;

	localparam int FRAC_W   = 24;
	localparam int RAND_W   = 16;
	localparam int RESULT_W = ((PROD_W + 6 * FRAC_W + 2 + 7) / 8) * 8;

	// One request beat as it goes out on the slave side.
	typedef struct packed {
		logic                 action;
		logic [IN_DATA_W-1:0] payload;
	} request_t;

	// One result beat, field by field.
	typedef struct packed {
		logic [31:0] sample_count;
		logic [23:0] image_u;
		logic [23:0] image_v;
		logic [24:0] stratum_width_u;
		logic [24:0] stratum_width_v;
		logic [23:0] aperture_u;
		logic [23:0] aperture_v;
		logic        last_sample;
	} sample_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = ACT_START;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [RESULT_W-1:0]   m_tdata;
	logic                  m_tlast;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	request_t pending_requests[$];
	sample_t  expected_samples[$];
	request_t drive_req;
	int       unaccepted = 0;
	int       mismatches = 0;
	int       sender_idle_pct = 0;
	int       receiver_stall_pct = 0;

	// Register copies held by the predictor.
	logic [7:0]  strata_pu = 8'd1;
	logic [7:0]  strata_pv = 8'd1;
	logic [7:0]  strata_lu = 8'd1;
	logic [7:0]  strata_lv = 8'd1;
	logic        jitter_pix_on = 1'b0;
	logic        jitter_lens_on = 1'b0;
	logic [15:0] columns = 16'd1;
	logic [15:0] rows = 16'd1;

	// Stratum odometer and latched pixel of the predictor.
	logic [7:0]  cnt_pu = '0;
	logic [7:0]  cnt_pv = '0;
	logic [7:0]  cnt_lu = '0;
	logic [7:0]  cnt_lv = '0;
	logic [15:0] pix_col = '0;
	logic [15:0] pix_row = '0;

	stratified_grid_sample_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#12ms;
		$display("simulation failed");
		$finish;
	end

	// A zero count or size behaves as one.
	function automatic logic [63:0] at_least_one(logic [15:0] v);
		return (v == 16'd0) ? 64'd1 : 64'(v);
	endfunction

	// Truncated fraction num/den; values of one or more saturate to all ones.
	function automatic logic [23:0] fraction(logic [63:0] num, logic [63:0] den);
		logic [127:0] quo;
		if (num >= den) begin
			return {FRAC_W{1'b1}};
		end
		quo = ({64'd0, num} << FRAC_W) / {64'd0, den};
		return quo[23:0];
	endfunction

	// Width 1/den; a full-width stratum is reported as 2^FRAC_W.
	function automatic logic [24:0] stratum_width(logic [63:0] den);
		if (den == 64'd1) begin
			return 25'h1000000;
		end
		return {1'b0, fraction(64'd1, den)};
	endfunction

	// Random offset when jittered, otherwise the stratum center.
	function automatic logic [63:0] offset(logic on, logic [15:0] raw);
		return on ? 64'(raw) : 64'(16'h8000);
	endfunction

	// Expected beat for one accepted request; steps the predictor state.
	function automatic sample_t advance_sampler(logic action, logic [IN_DATA_W-1:0] payload);
		sample_t res;
		logic [63:0] su, sv, lu, lv, cols_nz, rows_nz;
		logic wrap_pu, wrap_pv, wrap_lu, wrap_lv;
		su = at_least_one({8'd0, strata_pu});
		sv = at_least_one({8'd0, strata_pv});
		lu = at_least_one({8'd0, strata_lu});
		lv = at_least_one({8'd0, strata_lv});
		cols_nz = at_least_one(columns);
		rows_nz = at_least_one(rows);
		res = '0;
		if (action == ACT_START) begin
			pix_col = payload[15:0];
			pix_row = payload[31:16];
			cnt_pu = '0;
			cnt_pv = '0;
			cnt_lu = '0;
			cnt_lv = '0;
			res.sample_count = 32'(su * sv * lu * lv);
			return res;
		end
		res.image_u = fraction(((64'(pix_col) * su + 64'(cnt_pu)) << RAND_W)
			+ offset(jitter_pix_on, payload[47:32]), (su * cols_nz) << RAND_W);
		res.image_v = fraction(((64'(pix_row) * sv + 64'(cnt_pv)) << RAND_W)
			+ offset(jitter_pix_on, payload[63:48]), (sv * rows_nz) << RAND_W);
		res.stratum_width_u = stratum_width(su * cols_nz);
		res.stratum_width_v = stratum_width(sv * rows_nz);
		res.aperture_u = fraction((64'(cnt_lu) << RAND_W)
			+ offset(jitter_lens_on, payload[79:64]), lu << RAND_W);
		res.aperture_v = fraction((64'(cnt_lv) << RAND_W)
			+ offset(jitter_lens_on, payload[95:80]), lv << RAND_W);
		wrap_pu = 64'(cnt_pu) + 64'd1 >= su;
		wrap_pv = 64'(cnt_pv) + 64'd1 >= sv;
		wrap_lu = 64'(cnt_lu) + 64'd1 >= lu;
		wrap_lv = 64'(cnt_lv) + 64'd1 >= lv;
		res.last_sample = wrap_pu && wrap_pv && wrap_lu && wrap_lv;
		// Odometer: sub u, then sub v, then lens u, then lens v.
		if (!wrap_pu) begin
			cnt_pu = cnt_pu + 8'd1;
		end else begin
			cnt_pu = '0;
			if (!wrap_pv) begin
				cnt_pv = cnt_pv + 8'd1;
			end else begin
				cnt_pv = '0;
				if (!wrap_lu) begin
					cnt_lu = cnt_lu + 8'd1;
				end else begin
					cnt_lu = '0;
					cnt_lv = wrap_lv ? 8'd0 : cnt_lv + 8'd1;
				end
			end
		end
		return res;
	endfunction

	// Request driver: predicts on every accepted beat, then offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= ACT_START;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_samples.push_back(advance_sampler(s_tuser, s_tdata));
				unaccepted--;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					drive_req = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= drive_req.payload;
					s_tuser <= drive_req.action;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result();
		sample_t want;
		if (expected_samples.size() == 0) begin
			$error("result beat with no expectation pending");
			mismatches++;
		end else begin
			want = expected_samples.pop_front();
			compare_field("sample_count", want.sample_count, m_tdata[31:0]);
			compare_field("image_u", want.image_u, m_tdata[55:32]);
			compare_field("image_v", want.image_v, m_tdata[79:56]);
			compare_field("stratum_width_u", want.stratum_width_u, m_tdata[104:80]);
			compare_field("stratum_width_v", want.stratum_width_v, m_tdata[129:105]);
			compare_field("aperture_u", want.aperture_u, m_tdata[153:130]);
			compare_field("aperture_v", want.aperture_v, m_tdata[177:154]);
			compare_field("last_sample", want.last_sample, m_tlast);
		end
	endtask

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
			end
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	task automatic queue_request(logic action, logic [IN_DATA_W-1:0] payload);
		request_t req;
		req.action = action;
		req.payload = payload;
		pending_requests.push_back(req);
		unaccepted++;
	endtask

	// Random fractions ride along on start beats; the block ignores them there.
	task automatic queue_start(logic [15:0] col, logic [15:0] row);
		queue_request(ACT_START, {32'($urandom), 32'($urandom), row, col});
	endtask

	task automatic queue_next(logic [15:0] ru, logic [15:0] rv, logic [15:0] lu, logic [15:0] lv);
		queue_request(ACT_NEXT, {lv, lu, rv, ru, 32'($urandom)});
	endtask

	task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_PIX_STRATA_U: strata_pu = value[7:0];
			REG_PIX_STRATA_V: strata_pv = value[7:0];
			REG_LENS_STRATA_U: strata_lu = value[7:0];
			REG_LENS_STRATA_V: strata_lv = value[7:0];
			REG_JITTER_PIX: jitter_pix_on = value[0];
			REG_JITTER_LENS: jitter_lens_on = value[0];
			REG_IMG_COLUMNS: columns = value;
			REG_IMG_ROWS: rows = value;
			default: ;
		endcase
	endtask

	task automatic setup_sampler(logic [7:0] pu, logic [7:0] pv, logic [7:0] lu, logic [7:0] lv,
			logic jp, logic jl, logic [15:0] cols, logic [15:0] rws);
		write_register(REG_PIX_STRATA_U, 16'(pu));
		write_register(REG_PIX_STRATA_V, 16'(pv));
		write_register(REG_LENS_STRATA_U, 16'(lu));
		write_register(REG_LENS_STRATA_V, 16'(lv));
		write_register(REG_JITTER_PIX, 16'(jp));
		write_register(REG_JITTER_LENS, 16'(jl));
		write_register(REG_IMG_COLUMNS, cols);
		write_register(REG_IMG_ROWS, rws);
	endtask

	// Waits until every request is taken and every result is checked, then settles.
	task automatic wait_drained(int settle);
		while (unaccepted != 0 || expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_strata();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70) begin
			return 8'($urandom_range(1, 3));
		end else if (roll < 85) begin
			return 8'($urandom_range(4, 255));
		end else if (roll < 93) begin
			return 8'd0;
		end
		return 8'd255;
	endfunction

	function automatic logic [15:0] pick_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50) begin
			return 16'($urandom_range(1, 8));
		end else if (roll < 88) begin
			return 16'($urandom_range(1, 65535));
		end else if (roll < 94) begin
			return 16'd0;
		end
		return 16'hFFFF;
	endfunction

	// Mostly whole pixels: a start followed by its samples, sometimes cut short or run past
	// the end, with a few stray beats mixed in.
	task automatic run_pixels(int budget);
		int          issued;
		int          runs;
		longint      total;
		logic [15:0] col, row;
		issued = 0;
		// Counters left over from the previous setup step on before the first start.
		runs = $urandom_range(0, 3);
		repeat (runs) begin
			queue_next(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			issued++;
		end
		while (issued < budget) begin
			if ($urandom_range(99) < 8) begin
				queue_request(1'($urandom), {32'($urandom), 32'($urandom), 32'($urandom)});
				issued++;
			end else begin
				if ($urandom_range(99) < 85) begin
					col = 16'($urandom_range(0, int'(at_least_one(columns)) - 1));
					row = 16'($urandom_range(0, int'(at_least_one(rows)) - 1));
				end else begin
					col = 16'($urandom);
					row = 16'($urandom);
				end
				total = longint'(at_least_one({8'd0, strata_pu}))
					* longint'(at_least_one({8'd0, strata_pv}))
					* longint'(at_least_one({8'd0, strata_lu}))
					* longint'(at_least_one({8'd0, strata_lv}));
				runs = (total <= 48) ? int'(total) : $urandom_range(1, 32);
				if ($urandom_range(9) == 0) begin
					runs += $urandom_range(1, 3);
				end else if ($urandom_range(9) == 0 && runs > 1) begin
					runs = $urandom_range(1, runs - 1);
				end
				queue_start(col, row);
				issued++;
				repeat (runs) begin
					queue_next(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
					issued++;
				end
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A sample before any start uses the cleared pixel latch.
		queue_next(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// A pixel outside the image saturates its position.
		queue_start(16'hFFFF, 16'hFFFF);
		queue_next(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		queue_start(16'd0, 16'd0);
		queue_next(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
		queue_next(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
		wait_drained(16);

		// Full pixel of eight samples with jitter, then one more that wraps around.
		setup_sampler(8'd2, 8'd2, 8'd2, 8'd1, 1'b1, 1'b1, 16'd5, 16'd3);
		queue_start(16'd4, 16'd2);
		repeat (4) begin
			queue_next(16'h0000, 16'h0000, 16'h0000, 16'h0000);
			queue_next(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		end
		queue_next(16'h8001, 16'h7FFF, 16'h0001, 16'hFFFE);
		queue_start(16'd1, 16'd1);
		repeat (5) queue_next(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		wait_drained(16);

		// Counts lowered under running counters leave them beyond their range.
		write_register(REG_PIX_STRATA_U, 16'd1);
		write_register(REG_LENS_STRATA_U, 16'd1);
		queue_next(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
		queue_next(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
		wait_drained(16);

		// Random phases: extremes first, then mixed setups, each under one of four idling modes.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0) begin
				setup_sampler(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
			end else if (ph == 1) begin
				setup_sampler(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0);
			end else begin
				setup_sampler(pick_strata(), pick_strata(), pick_strata(), pick_strata(),
					1'($urandom), 1'($urandom), pick_size(), pick_size());
			end
			case (ph % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 80;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 80;
				end
				default: begin
					sender_idle_pct = 38;
					receiver_stall_pct = 38;
				end
			endcase
			run_pixels(135);
			wait_drained(16);
		end

		wait_drained(250);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
